/* rtl/laplace_2d_bem_kernel_macros.svh */
// assertion macros used by the checker file
`ifndef LAPLACE_2D_BEM_KERNEL_MACROS_SVH
`define LAPLACE_2D_BEM_KERNEL_MACROS_SVH

// same-cycle implication, disabled in reset
`define LBEM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbem assertion failed");

// implication after a fixed number of cycles
`define LBEM_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("lbem latency assertion failed");

`endif

/* rtl/lbem_pkg.sv */
// shared types, constants and helper functions of the bem kernel
package lbem_pkg;

  localparam int K_W      = 35;
  localparam int LG_W     = 37;
  localparam int Z_W      = 35;
  localparam int XY_W     = 40;
  localparam int N_FRAC   = 30;
  localparam int PIPE_LAT = 43;

  typedef logic signed [K_W-1:0]  k_t;
  typedef logic signed [LG_W-1:0] lg_t;
  typedef logic signed [Z_W-1:0]  z_t;

  localparam logic signed [32:0] LN2_Q32    = 33'sd2977044472;
  localparam logic signed [32:0] INV2PI_Q32 = 33'sd683565276;
  localparam z_t                 PI_Q30     = 35'sd3373259426;
  localparam lg_t                LOG2_ZERO  = {1'b1, {(LG_W-1){1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/lbem_mul.sv */
// two-stage signed multiplier with floor shift, split into two partial products
module lbem_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int SH = 0,
  parameter int WR = 64
) (
  input  logic                 clk,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WR-1:0] p
);
  localparam int LO = WA / 2;
  localparam int HI = WA - LO;
  localparam int FW = WA + WB + 1;

  logic signed [LO+WB:0]   pl;
  logic signed [HI+WB-1:0] ph;
  logic signed [FW-1:0]    full;
  logic signed [FW-1:0]    shd;

  always_ff @(posedge clk) begin
    pl <= $signed({1'b0, a[LO-1:0]}) * b;
    ph <= $signed(a[WA-1:LO]) * b;
  end

  assign full = (FW'(ph) <<< LO) + FW'(pl);
  // arithmetic shift rounds toward minus infinity
  assign shd  = full >>> SH;

  always_ff @(posedge clk) begin
    p <= shd[WR-1:0];
  end
endmodule

/* rtl/lbem_delay.sv */
// fixed-length delay line for payload that rides beside the datapath
module lbem_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < N; i++) taps[i] <= taps[i-1];
  end

  assign q = taps[N-1];
endmodule

/* rtl/lbem_lg2.sv */
// pipelined log2 by repeated squaring, 30 fraction bits
module lbem_lg2 (
  input  logic          clk,
  input  logic [63:0]   v,
  output lbem_pkg::lg_t res
);
  import lbem_pkg::*;

  logic [63:0] va;
  logic [5:0]  ea;
  logic        za;
  logic [5:0]  msb;

  logic [31:0] m_q [31];
  logic [29:0] f_q [31];
  logic [5:0]  e_q [31];
  logic        z_q [31];
  logic [63:0] sq  [30];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 64; i++) if (v[i]) msb = 6'(i);
  end

  always_comb begin
    for (int j = 0; j < 30; j++) sq[j] = 64'(m_q[j]) * 64'(m_q[j]);
  end

  always_ff @(posedge clk) begin
    va <= v;
    ea <= msb;
    za <= (v == 64'd0);
    // normalize to a mantissa in [2^31, 2^32)
    m_q[0] <= (ea >= 6'd31) ? 32'(va >> (ea - 6'd31)) : 32'(va << (6'd31 - ea));
    f_q[0] <= '0;
    e_q[0] <= ea;
    z_q[0] <= za;
    for (int j = 0; j < 30; j++) begin
      m_q[j+1] <= sq[j][63] ? sq[j][63:32] : sq[j][62:31];
      f_q[j+1] <= sq[j][63] ? (f_q[j] | (30'(1) << (29 - j))) : f_q[j];
      e_q[j+1] <= e_q[j];
      z_q[j+1] <= z_q[j];
    end
  end

  assign res = z_q[30] ? LOG2_ZERO : $signed({1'b0, e_q[30], f_q[30]});
endmodule

/* rtl/lbem_atan.sv */
// pipelined cordic atan2 in vectoring mode, 30 fraction bits
module lbem_atan (
  input  logic          clk,
  input  lbem_pkg::k_t  y,
  input  lbem_pkg::k_t  x,
  output lbem_pkg::z_t  z
);
  import lbem_pkg::*;

  logic [33:0] ax, ay, o;
  logic [5:0]  msb;

  k_t                     xa, ya;
  logic [5:0]             na;
  logic                   za;
  logic signed [XY_W-1:0] xb, yb;
  logic                   zb;

  logic signed [XY_W-1:0] cx [32];
  logic signed [XY_W-1:0] cy [32];
  z_t                     cz [32];
  logic                   cn [32];
  logic signed [XY_W-1:0] xn [31];
  logic signed [XY_W-1:0] yn [31];
  z_t                     zn [31];

  always_comb begin
    ax  = x[K_W-1] ? 34'(-x) : 34'(x);
    ay  = y[K_W-1] ? 34'(-y) : 34'(y);
    o   = ax | ay;
    msb = '0;
    for (int i = 0; i < 34; i++) if (o[i]) msb = 6'(i);
  end

  always_comb begin
    for (int i = 0; i < 31; i++) begin
      if (!cy[i][XY_W-1]) begin
        xn[i] = cx[i] + (cy[i] >>> i);
        yn[i] = cy[i] - (cx[i] >>> i);
        zn[i] = cz[i] + $signed({3'b000, atan_tab(5'(i))});
      end else begin
        xn[i] = cx[i] - (cy[i] >>> i);
        yn[i] = cy[i] + (cx[i] >>> i);
        zn[i] = cz[i] - $signed({3'b000, atan_tab(5'(i))});
      end
    end
  end

  always_ff @(posedge clk) begin
    // prescale until the larger magnitude reaches 2^33
    xa <= x;
    ya <= y;
    na <= (msb < 6'd33) ? (6'd33 - msb) : 6'd0;
    za <= (o == 34'd0);
    xb <= XY_W'(xa) <<< na;
    yb <= XY_W'(ya) <<< na;
    zb <= za;
    // left half plane folds by a half turn
    if (xb[XY_W-1]) begin
      cx[0] <= -xb;
      cy[0] <= -yb;
      cz[0] <= yb[XY_W-1] ? -PI_Q30 : PI_Q30;
    end else begin
      cx[0] <= xb;
      cy[0] <= yb;
      cz[0] <= '0;
    end
    cn[0] <= zb;
    for (int i = 0; i < 31; i++) begin
      cx[i+1] <= xn[i];
      cy[i+1] <= yn[i];
      cz[i+1] <= zn[i];
      cn[i+1] <= cn[i];
    end
  end

  assign z = cn[31] ? '0 : cz[31];
endmodule

/* rtl/laplace_2d_bem_kernel.sv */
// top level: 2d laplace constant-element influence coefficients, one pair per cycle
// throughput: one transaction per cycle, busy stays low; depth is set by the
// 30-step log2 squaring chain and the 31-step cordic pipeline in parallel
// reset clears the valid chain, the done strobe and exterior_side
module laplace_2d_bem_kernel #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] source_mid_x,
  input  logic signed [31:0] source_mid_y,
  input  logic signed [31:0] seg_start_x,
  input  logic signed [31:0] seg_start_y,
  input  logic signed [31:0] seg_end_x,
  input  logic signed [31:0] seg_end_y,
  input  logic [30:0]        seg_length,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  output logic               done,
  output logic signed [31:0] single_layer,
  output logic signed [31:0] double_layer,
  output logic               self_term
);
  import lbem_pkg::*;

  localparam logic [64:0] SELF_LIMIT =
    65'((65'd1 << (2 * FRAC_BITS)) / 65'd100000000);
  localparam logic signed [37:0] SELF_OFS = 38'(FRAC_BITS + 1) <<< N_FRAC;
  localparam logic signed [37:0] RAD_OFS  = 38'(2 * FRAC_BITS) <<< N_FRAC;
  localparam logic signed [31:0] HALF     = 32'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [40:0] ONE_Q30  = 41'(1) <<< N_FRAC;
  localparam int DL_SH = 62 - FRAC_BITS;
  localparam int KD_W  = 3 * K_W + 31;

  logic exterior_side;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exterior_side <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      exterior_side <= cfg_data;
    end
  end

  // valid chain
  logic        v0, v1, v2, v3;
  logic [37:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      vpipe <= '0;
    end else begin
      v0    <= start && !busy;
      v1    <= v0;
      v2    <= v1;
      v3    <= v2;
      vpipe <= {vpipe[36:0], v3};
    end
  end

  // input register
  logic signed [31:0] s0_tx, s0_ty, s0_mx, s0_my, s0_ax, s0_ay, s0_bx, s0_by;
  logic signed [31:0] s0_nx, s0_ny;
  logic [30:0]        s0_hy;

  always_ff @(posedge clk) begin
    s0_tx <= target_x;
    s0_ty <= target_y;
    s0_mx <= source_mid_x;
    s0_my <= source_mid_y;
    s0_ax <= seg_start_x;
    s0_ay <= seg_start_y;
    s0_bx <= seg_end_x;
    s0_by <= seg_end_y;
    s0_hy <= seg_length;
    s0_nx <= normal_x;
    s0_ny <= normal_y;
  end

  // stage 1: offsets
  logic signed [32:0] d_mx, d_my;
  logic signed [31:0] s1_r1x, s1_r1y, s1_r2x, s1_r2y, s1_nx, s1_ny;
  logic [31:0]        s1_ux, s1_uy;
  logic [30:0]        s1_hy;

  assign d_mx = 33'(s0_tx) - 33'(s0_mx);
  assign d_my = 33'(s0_ty) - 33'(s0_my);

  always_ff @(posedge clk) begin
    s1_r1x <= sat32(64'(33'(s0_tx) - 33'(s0_ax)));
    s1_r1y <= sat32(64'(33'(s0_ty) - 33'(s0_ay)));
    s1_r2x <= sat32(64'(33'(s0_tx) - 33'(s0_bx)));
    s1_r2y <= sat32(64'(33'(s0_ty) - 33'(s0_by)));
    s1_ux  <= d_mx[32] ? 32'(-d_mx) : d_mx[31:0];
    s1_uy  <= d_my[32] ? 32'(-d_my) : d_my[31:0];
    s1_nx  <= s0_nx;
    s1_ny  <= s0_ny;
    s1_hy  <= s0_hy;
  end

  // stage 2: products with the normal and squares
  logic signed [63:0] pr [8];
  logic signed [33:0] s2_p [8];
  logic [63:0]        s2_q1x, s2_q1y, s2_q2x, s2_q2y, s2_s1, s2_s2;
  logic [30:0]        s2_hy;

  always_comb begin
    pr[0] = s1_r1x * s1_nx;
    pr[1] = s1_r1y * s1_ny;
    pr[2] = s1_r1y * s1_nx;
    pr[3] = s1_r1x * s1_ny;
    pr[4] = s1_r2x * s1_nx;
    pr[5] = s1_r2y * s1_ny;
    pr[6] = s1_r2y * s1_nx;
    pr[7] = s1_r2x * s1_ny;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) s2_p[i] <= pr[i][63:N_FRAC];
    s2_q1x <= 64'(s1_r1x * s1_r1x);
    s2_q1y <= 64'(s1_r1y * s1_r1y);
    s2_q2x <= 64'(s1_r2x * s1_r2x);
    s2_q2y <= 64'(s1_r2y * s1_r2y);
    s2_s1  <= 64'(s1_ux) * 64'(s1_ux);
    s2_s2  <= 64'(s1_uy) * 64'(s1_uy);
    s2_hy  <= s1_hy;
  end

  // stage 3: dot and cross products, squared radii, self test
  k_t          s3_k1, s3_k2, s3_k3, s3_k4;
  logic [63:0] s3_q1, s3_q2;
  logic        s3_self;
  logic [30:0] s3_hy;

  always_ff @(posedge clk) begin
    s3_k1   <= K_W'(s2_p[0]) + K_W'(s2_p[1]);
    s3_k2   <= K_W'(s2_p[2]) - K_W'(s2_p[3]);
    s3_k3   <= K_W'(s2_p[4]) + K_W'(s2_p[5]);
    s3_k4   <= K_W'(s2_p[6]) - K_W'(s2_p[7]);
    s3_q1   <= s2_q1x + s2_q1y;
    s3_q2   <= s2_q2x + s2_q2y;
    // a sum past 64 bits can never be below the limit
    s3_self <= ({1'b0, s2_s1} + {1'b0, s2_s2}) < SELF_LIMIT;
    s3_hy   <= s2_hy;
  end

  // log and angle units
  lg_t lg_h, lg_1, lg_2;
  z_t  at_12, at_34;

  lbem_lg2 u_lg_h (.clk(clk), .v({33'd0, s3_hy}), .res(lg_h));
  lbem_lg2 u_lg_1 (.clk(clk), .v(s3_q1), .res(lg_1));
  lbem_lg2 u_lg_2 (.clk(clk), .v(s3_q2), .res(lg_2));

  lbem_atan u_at_12 (.clk(clk), .y(s3_k1), .x(s3_k2), .z(at_12));
  lbem_atan u_at_34 (.clk(clk), .y(s3_k3), .x(s3_k4), .z(at_34));

  // side data delays
  logic [KD_W-1:0] kd_q;
  k_t              k1_d, k2_d, k4_d;
  logic [30:0]     hy_d34, hy_d36;
  logic            self_d;

  lbem_delay #(.W(KD_W), .N(34)) u_dly_k (
    .clk(clk), .d({s3_k1, s3_k2, s3_k4, s3_hy}), .q(kd_q)
  );
  assign k1_d   = kd_q[KD_W-1 -: K_W];
  assign k2_d   = kd_q[KD_W-1-K_W -: K_W];
  assign k4_d   = kd_q[KD_W-1-2*K_W -: K_W];
  assign hy_d34 = kd_q[30:0];

  lbem_delay #(.W(31), .N(2)) u_dly_hy (.clk(clk), .d(hy_d34), .q(hy_d36));
  lbem_delay #(.W(1), .N(38)) u_dly_self (.clk(clk), .d(s3_self), .q(self_d));

  // self path
  logic signed [37:0] xh;
  logic signed [39:0] lnh;
  logic signed [40:0] ylnh;
  logic signed [41:0] t_self, sl_self;

  assign xh = 38'(lg_h) - SELF_OFS;

  lbem_mul #(.WA(38), .WB(33), .SH(32), .WR(40)) u_mul_lnh (
    .clk(clk), .a(xh), .b(LN2_Q32), .p(lnh)
  );

  assign ylnh = ONE_Q30 - 41'(lnh);

  lbem_mul #(.WA(32), .WB(41), .SH(N_FRAC), .WR(42)) u_mul_t (
    .clk(clk), .a($signed({1'b0, hy_d34})), .b(ylnh), .p(t_self)
  );

  lbem_mul #(.WA(42), .WB(33), .SH(32), .WR(42)) u_mul_sls (
    .clk(clk), .a(t_self), .b(INV2PI_Q32), .p(sl_self)
  );

  // regular path
  logic signed [37:0] x1, x2;
  logic signed [39:0] lnr1, lnr2;
  logic signed [35:0] ang;
  logic signed [45:0] p1, p2, p3;
  logic signed [47:0] sum;
  logic signed [47:0] sl_main;
  logic signed [39:0] dl_main, dl_d;

  assign x1 = 38'(lg_1) - RAD_OFS;
  assign x2 = 38'(lg_2) - RAD_OFS;

  lbem_mul #(.WA(38), .WB(33), .SH(33), .WR(40)) u_mul_lnr1 (
    .clk(clk), .a(x1), .b(LN2_Q32), .p(lnr1)
  );
  lbem_mul #(.WA(38), .WB(33), .SH(33), .WR(40)) u_mul_lnr2 (
    .clk(clk), .a(x2), .b(LN2_Q32), .p(lnr2)
  );

  assign ang = 36'(at_34) - 36'(at_12);

  lbem_mul #(.WA(K_W), .WB(40), .SH(N_FRAC), .WR(46)) u_mul_p1 (
    .clk(clk), .a(k4_d), .b(lnr2), .p(p1)
  );
  lbem_mul #(.WA(K_W), .WB(40), .SH(N_FRAC), .WR(46)) u_mul_p2 (
    .clk(clk), .a(k2_d), .b(lnr1), .p(p2)
  );
  lbem_mul #(.WA(K_W), .WB(36), .SH(N_FRAC), .WR(46)) u_mul_p3 (
    .clk(clk), .a(k1_d), .b(ang), .p(p3)
  );
  lbem_mul #(.WA(36), .WB(33), .SH(DL_SH), .WR(40)) u_mul_dl (
    .clk(clk), .a(ang), .b(INV2PI_Q32), .p(dl_main)
  );

  assign sum = 48'(p1) - 48'(p2) + $signed({17'd0, hy_d36}) - 48'(p3);

  lbem_mul #(.WA(48), .WB(33), .SH(32), .WR(48)) u_mul_sl (
    .clk(clk), .a(sum), .b(INV2PI_Q32), .p(sl_main)
  );

  lbem_delay #(.W(40), .N(2)) u_dly_dl (.clk(clk), .d(dl_main), .q(dl_d));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vpipe[37];
    end
  end

  always_ff @(posedge clk) begin
    self_term <= self_d;
    if (self_d) begin
      single_layer <= sat32(64'(sl_self));
      double_layer <= exterior_side ? -HALF : HALF;
    end else begin
      single_layer <= sat32(64'(sl_main));
      double_layer <= sat32(64'(dl_d));
    end
  end
endmodule

/* rtl/lbem_checker.sv */
// port-level checker for the bem kernel and its bind
`include "laplace_2d_bem_kernel_macros.svh"

module lbem_checker #(
  parameter int FRAC_BITS = 24
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               self_term,
  input logic signed [31:0] double_layer
);
  import lbem_pkg::*;

  localparam logic signed [31:0] HALF = 32'(1) <<< (FRAC_BITS - 1);

  // every accepted transaction yields a result after the fixed latency
  `LBEM_ASSERT_DELAY(a_result_follows, start && !busy, PIPE_LAT, done)

  // no result without a transaction accepted at the matching time
  `LBEM_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, PIPE_LAT))

  // self terms carry a double layer of plus or minus one half
  `LBEM_ASSERT_IMPL(a_self_half, done && self_term, double_layer == HALF || double_layer == -HALF)
endmodule

bind laplace_2d_bem_kernel lbem_checker #(.FRAC_BITS(FRAC_BITS)) u_lbem_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .self_term(self_term),
  .double_layer(double_layer)
);
